// ----- rtl/core/ias_pkg.sv -----
// Package with shared types, constants and helper functions for the inactivity alert sequencer.
package ias_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TICK_WIDTH  = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH;
    localparam int PCT_WIDTH   = 7;
    localparam int CODE_WIDTH  = 3;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;

    localparam logic [PCT_WIDTH-1:0] PCT_MAX = PCT_WIDTH'(100);

    localparam logic [TICK_WIDTH-1:0] PHASE_TICKS_RST  = TICK_WIDTH'(10000);
    localparam logic [TICK_WIDTH-1:0] BLINK_TICKS_RST  = TICK_WIDTH'(500);
    localparam logic [PCT_WIDTH-1:0]  BRIGHT_LEVEL_RST = PCT_WIDTH'(100);
    localparam logic [PCT_WIDTH-1:0]  DIM_LEVEL_RST    = PCT_WIDTH'(20);

    localparam logic [1:0] REG_PHASE_TICKS  = 2'd0;
    localparam logic [1:0] REG_BLINK_TICKS  = 2'd1;
    localparam logic [1:0] REG_BRIGHT_LEVEL = 2'd2;
    localparam logic [1:0] REG_DIM_LEVEL    = 2'd3;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    localparam logic [CODE_WIDTH-1:0] CODE_OFF    = 3'd0;
    localparam logic [CODE_WIDTH-1:0] CODE_ALERT1 = 3'd1;
    localparam logic [CODE_WIDTH-1:0] CODE_BREAK1 = 3'd2;
    localparam logic [CODE_WIDTH-1:0] CODE_ALERT2 = 3'd3;
    localparam logic [CODE_WIDTH-1:0] CODE_BREAK2 = 3'd4;
    localparam logic [CODE_WIDTH-1:0] CODE_ALERT3 = 3'd5;
    localparam logic [CODE_WIDTH-1:0] CODE_FINAL  = 3'd6;

    typedef enum logic [6:0] {
        PHASE_OFF    = 7'b0000001,
        PHASE_ALERT1 = 7'b0000010,
        PHASE_BREAK1 = 7'b0000100,
        PHASE_ALERT2 = 7'b0001000,
        PHASE_BREAK2 = 7'b0010000,
        PHASE_ALERT3 = 7'b0100000,
        PHASE_FINAL  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [TICK_WIDTH-1:0] phase_ticks;
        logic [TICK_WIDTH-1:0] blink_ticks;
        logic [PCT_WIDTH-1:0]  bright_level;
        logic [PCT_WIDTH-1:0]  dim_level;
    } t_cfg;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [PCT_WIDTH-1:0] clamp_pct(input logic [PCT_WIDTH-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    function automatic logic is_alert(input t_phase p);
        return (p == PHASE_ALERT1) || (p == PHASE_ALERT2) || (p == PHASE_ALERT3);
    endfunction

    function automatic t_phase next_phase(input t_phase p);
        t_phase n;
        unique case (p)
            PHASE_ALERT1: n = PHASE_BREAK1;
            PHASE_BREAK1: n = PHASE_ALERT2;
            PHASE_ALERT2: n = PHASE_BREAK2;
            PHASE_BREAK2: n = PHASE_ALERT3;
            default:      n = PHASE_FINAL;
        endcase
        return n;
    endfunction

    function automatic logic [CODE_WIDTH-1:0] phase_code(input t_phase p);
        logic [CODE_WIDTH-1:0] c;
        unique case (p)
            PHASE_ALERT1: c = CODE_ALERT1;
            PHASE_BREAK1: c = CODE_BREAK1;
            PHASE_ALERT2: c = CODE_ALERT2;
            PHASE_BREAK2: c = CODE_BREAK2;
            PHASE_ALERT3: c = CODE_ALERT3;
            PHASE_FINAL:  c = CODE_FINAL;
            default:      c = CODE_OFF;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/ias_if.sv -----
// Handshake interfaces for the request and result channels.
interface ias_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic want_active;

    modport source(output valid, output req_type, output want_active, input ready);
    modport sink(input valid, input req_type, input want_active, output ready);
endinterface

interface ias_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic [6:0] backlight_pct;
    logic       unmute;
    logic       beep_start;
    logic       overlay_visible;
    logic       sleep_request;

    modport source(output valid, output phase, output backlight_pct, output unmute,
                   output beep_start, output overlay_visible, output sleep_request,
                   input ready);
    modport sink(input valid, input phase, input backlight_pct, input unmute,
                 input beep_start, input overlay_visible, input sleep_request,
                 output ready);
endinterface

// ----- rtl/core/ias_cfg.sv -----
// APB configuration register file for the inactivity alert sequencer.
module ias_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ias_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [ias_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [ias_pkg::DATA_WIDTH-1:0] prdata,
    output logic                         pready,
    output ias_pkg::t_cfg                o_cfg
);
    import ias_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks  <= PHASE_TICKS_RST;
            r_cfg.blink_ticks  <= BLINK_TICKS_RST;
            r_cfg.bright_level <= BRIGHT_LEVEL_RST;
            r_cfg.dim_level    <= DIM_LEVEL_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PHASE_TICKS:  r_cfg.phase_ticks  <= pwdata[TICK_WIDTH-1:0];
                REG_BLINK_TICKS:  r_cfg.blink_ticks  <= pwdata[TICK_WIDTH-1:0];
                REG_BRIGHT_LEVEL: r_cfg.bright_level <= pwdata[PCT_WIDTH-1:0];
                REG_DIM_LEVEL:    r_cfg.dim_level    <= pwdata[PCT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PHASE_TICKS:  prdata = DATA_WIDTH'(r_cfg.phase_ticks);
            REG_BLINK_TICKS:  prdata = DATA_WIDTH'(r_cfg.blink_ticks);
            REG_BRIGHT_LEVEL: prdata = DATA_WIDTH'(r_cfg.bright_level);
            REG_DIM_LEVEL:    prdata = DATA_WIDTH'(r_cfg.dim_level);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/inactivity_alert_sequencer.sv -----
// Top level of the inactivity alert sequencer.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the result channel is not stalled; the state register update sets this figure.
// While a result waits, the input register takes one more item and then holds the input.
// Reset is synchronous and active low; it returns the sequencer to off and the registers
// to their defaults.
module inactivity_alert_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ias_in_if.sink                         i_in,
    ias_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ias_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [ias_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [ias_pkg::DATA_WIDTH-1:0] prdata,
    output logic                           pready
);
    import ias_pkg::*;

    t_cfg cfg;

    ias_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic r_in_valid;
    logic r_in_req_type;
    logic r_in_want;
    logic adv_out;
    logic fire;

    logic                   r_active, n_active;
    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_phase_count, n_phase_count;
    logic [COUNT_WIDTH-1:0] r_blink_count, n_blink_count;
    logic                   r_blink_armed, n_blink_armed;
    logic                   r_blink_lit, n_blink_lit;
    logic [PCT_WIDTH-1:0]   r_level, n_level;
    logic                   r_unmute, n_unmute;
    logic                   n_beep;
    logic                   n_sleep;

    logic                   r_out_valid;
    logic [CODE_WIDTH-1:0]  r_res_phase;
    logic [PCT_WIDTH-1:0]   r_res_level;
    logic                   r_res_unmute;
    logic                   r_res_beep;
    logic                   r_res_overlay;
    logic                   r_res_sleep;

    logic [TICK_WIDTH-1:0]  period;
    logic [COUNT_WIDTH-1:0] pc_inc;
    logic [COUNT_WIDTH-1:0] bc_inc;
    logic                   blink_toggle;

    assign adv_out    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && adv_out;
    assign i_in.ready = !r_in_valid || adv_out;
    assign period     = (cfg.phase_ticks == '0) ? TICK_WIDTH'(1) : cfg.phase_ticks;

    always_comb begin
        n_active      = r_active;
        n_phase       = r_phase;
        n_phase_count = r_phase_count;
        n_blink_count = r_blink_count;
        n_blink_armed = r_blink_armed;
        n_blink_lit   = r_blink_lit;
        n_level       = r_level;
        n_unmute      = r_unmute;
        n_beep        = 1'b0;
        n_sleep       = 1'b0;
        pc_inc        = sat_inc(r_phase_count);
        bc_inc        = '0;
        blink_toggle  = 1'b0;

        if (r_in_req_type == REQ_SET) begin
            if (r_in_want != r_active) begin
                n_active      = r_in_want;
                n_phase       = r_in_want ? PHASE_ALERT1 : PHASE_OFF;
                n_phase_count = '0;
                n_blink_count = '0;
                n_blink_armed = 1'b0;
                n_blink_lit   = 1'b0;
                n_level       = r_in_want ? clamp_pct(cfg.dim_level)
                                          : clamp_pct(cfg.bright_level);
                n_unmute      = 1'b0;
            end
        end else if (r_active && r_phase != PHASE_OFF && r_phase != PHASE_FINAL) begin
            n_phase_count = pc_inc;
            if (CMP_WIDTH'(pc_inc) >= CMP_WIDTH'(period)) begin
                n_phase       = next_phase(r_phase);
                n_phase_count = '0;
                n_blink_count = '0;
                n_blink_armed = 1'b0;
                n_blink_lit   = 1'b0;
                n_level       = is_alert(n_phase) ? clamp_pct(cfg.dim_level)
                                                  : clamp_pct(cfg.bright_level);
                n_unmute      = 1'b0;
                n_sleep       = (n_phase == PHASE_FINAL);
            end
            if (is_alert(n_phase)) begin
                blink_toggle = 1'b1;
                if (n_blink_armed) begin
                    bc_inc        = sat_inc(n_blink_count);
                    n_blink_count = bc_inc;
                    blink_toggle  = CMP_WIDTH'(bc_inc) >= CMP_WIDTH'(cfg.blink_ticks);
                end
                if (blink_toggle) begin
                    n_blink_armed = 1'b1;
                    n_blink_count = '0;
                    n_blink_lit   = !n_blink_lit;
                    n_level       = n_blink_lit ? clamp_pct(cfg.bright_level)
                                                : clamp_pct(cfg.dim_level);
                    n_unmute      = n_blink_lit;
                    n_beep        = n_blink_lit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_req_type <= i_in.req_type;
            r_in_want     <= i_in.want_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_phase       <= PHASE_OFF;
            r_phase_count <= '0;
            r_blink_count <= '0;
            r_blink_armed <= 1'b0;
            r_blink_lit   <= 1'b0;
            r_level       <= BRIGHT_LEVEL_RST;
            r_unmute      <= 1'b0;
        end else if (fire) begin
            r_active      <= n_active;
            r_phase       <= n_phase;
            r_phase_count <= n_phase_count;
            r_blink_count <= n_blink_count;
            r_blink_armed <= n_blink_armed;
            r_blink_lit   <= n_blink_lit;
            r_level       <= n_level;
            r_unmute      <= n_unmute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res_phase   <= phase_code(n_phase);
            r_res_level   <= n_level;
            r_res_unmute  <= n_unmute;
            r_res_beep    <= n_beep;
            r_res_overlay <= n_active && is_alert(n_phase);
            r_res_sleep   <= n_sleep;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.phase           = r_res_phase;
    assign o_out.backlight_pct   = r_res_level;
    assign o_out.unmute          = r_res_unmute;
    assign o_out.beep_start      = r_res_beep;
    assign o_out.overlay_visible = r_res_overlay;
    assign o_out.sleep_request   = r_res_sleep;

endmodule
